// File: hdl/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/lkvc_pkg.sv
// Shared types, codes and defaults of the LRU key/value cache.
`default_nettype none

package lkvc_pkg;

    localparam int DEF_ENTRIES    = 16;
    localparam int DEF_KEY_BITS   = 32;
    localparam int DEF_VALUE_BITS = 32;

    localparam int FIELD_BITS = 32;
    localparam int MODE_BITS  = 2;
    localparam int EVENT_BITS = 2;
    localparam int CAP_BITS   = 5;

    localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

    localparam logic [MODE_BITS-1:0] MODE_GET   = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_PUT   = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_ERASE = 2'd2;

    localparam logic [EVENT_BITS-1:0] EV_NONE   = 2'd0;
    localparam logic [EVENT_BITS-1:0] EV_INSERT = 2'd1;
    localparam logic [EVENT_BITS-1:0] EV_UPDATE = 2'd2;
    localparam logic [EVENT_BITS-1:0] EV_DELETE = 2'd3;

    // update command broadcast to every cell
    typedef enum logic [1:0] {
        OP_NOP,
        OP_TOUCH,
        OP_INSERT,
        OP_DROP
    } op_t;

    typedef struct packed {
        op_t  op;
        logic write;   // touch also overwrites the value
        logic evict;   // insert pushes out the least recent entry
    } cmd_t;

    // single-bit flags passed cell to cell during lookup
    typedef struct packed {
        logic hit;       // some earlier cell matched the key
        logic claimed;   // some earlier cell took the insert slot
    } chain_t;

endpackage

`default_nettype wire

// File: hdl/lkvc_cell.sv
// One cache entry: key, value, recency rank, and its link in the lookup chain.
`default_nettype none

module lkvc_cell #(
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32,
    parameter int RANK_BITS  = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  look,
    input  logic [KEY_BITS-1:0]   look_key,
    input  logic [RANK_BITS-1:0]  lru_rank,
    input  logic                  evict_look,
    input  lkvc_pkg::cmd_t        cmd,
    input  logic [RANK_BITS-1:0]  ref_rank,
    input  logic [KEY_BITS-1:0]   new_key,
    input  logic [VALUE_BITS-1:0] new_value,
    input  lkvc_pkg::chain_t      chain_in,
    output lkvc_pkg::chain_t      chain_out,
    input  logic [RANK_BITS-1:0]  rank_in,
    output logic [RANK_BITS-1:0]  rank_out,
    input  logic [VALUE_BITS-1:0] value_in,
    output logic [VALUE_BITS-1:0] value_out,
    input  logic [KEY_BITS-1:0]   evkey_in,
    output logic [KEY_BITS-1:0]   evkey_out
);

    import lkvc_pkg::*;

    logic                  valid_reg, valid_next;
    logic [RANK_BITS-1:0]  rank_reg, rank_next;
    logic                  match_reg, match_next;
    logic                  lru_reg, lru_next;
    logic                  slot_reg, slot_next;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] value_reg;

    logic match_now;
    logic lru_now;
    logic cand;
    logic wr_key;
    logic wr_value;

    assign match_now = valid_reg && (key_reg == look_key);
    assign lru_now   = valid_reg && (rank_reg == lru_rank);
    // free slot, or the victim when this put will evict
    assign cand      = !valid_reg || (evict_look && lru_now);

    assign chain_out.hit     = chain_in.hit | match_now;
    assign chain_out.claimed = chain_in.claimed | cand;
    assign rank_out  = rank_in | (match_now ? rank_reg : '0);
    assign value_out = value_in | (match_now ? value_reg : '0);
    assign evkey_out = evkey_in | ((lru_now && evict_look) ? key_reg : '0);

    assign wr_key   = (cmd.op == OP_INSERT) && slot_reg;
    assign wr_value = wr_key || ((cmd.op == OP_TOUCH) && cmd.write && match_reg);

    always_comb
    begin
        valid_next = valid_reg;
        rank_next  = rank_reg;
        match_next = match_reg;
        lru_next   = lru_reg;
        slot_next  = slot_reg;

        if (look)
        begin
            match_next = match_now;
            lru_next   = lru_now;
            slot_next  = cand && !chain_in.claimed;
        end

        case (cmd.op)
            OP_TOUCH:
            begin
                if (match_reg)
                    rank_next = '0;
                else if (valid_reg && (rank_reg < ref_rank))
                    rank_next = rank_reg + RANK_BITS'(1);
            end
            OP_INSERT:
            begin
                if (slot_reg)
                begin
                    valid_next = 1'b1;
                    rank_next  = '0;
                end
                else if (lru_reg && cmd.evict)
                begin
                    valid_next = 1'b0;
                    rank_next  = '0;
                end
                else if (valid_reg)
                    rank_next = rank_reg + RANK_BITS'(1);
            end
            OP_DROP:
            begin
                if (match_reg)
                begin
                    valid_next = 1'b0;
                    rank_next  = '0;
                end
                else if (valid_reg && (rank_reg > ref_rank))
                    rank_next = rank_reg - RANK_BITS'(1);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rank_reg  <= '0;
            match_reg <= 1'b0;
            lru_reg   <= 1'b0;
            slot_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
            match_reg <= match_next;
            lru_reg   <= lru_next;
            slot_reg  <= slot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_key)
            key_reg <= new_key;
        if (wr_value)
            value_reg <= new_value;
    end

endmodule

`default_nettype wire

// File: hdl/lkvc_ctrl.sv
// Sequencer: handshakes, capacity register, occupancy, update command, result register.
`default_nettype none

module lkvc_ctrl #(
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32,
    parameter int ENTRIES    = 16,
    parameter int RANK_BITS  = 4,
    parameter int OCC_BITS   = 5
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [lkvc_pkg::MODE_BITS-1:0]      mode,
    input  logic [KEY_BITS-1:0]                 look_key,
    input  logic [VALUE_BITS-1:0]               look_value,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lkvc_pkg::CAP_BITS-1:0]       cfg_data,
    input  lkvc_pkg::chain_t                    chain_end,
    input  logic [RANK_BITS-1:0]                rank_end,
    input  logic [VALUE_BITS-1:0]               value_end,
    input  logic [KEY_BITS-1:0]                 evkey_end,
    output logic                                look,
    output logic [RANK_BITS-1:0]                lru_rank,
    output logic                                evict_look,
    output lkvc_pkg::cmd_t                      cmd,
    output logic [RANK_BITS-1:0]                ref_rank,
    output logic [KEY_BITS-1:0]                 new_key,
    output logic [VALUE_BITS-1:0]               new_value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                hit,
    output logic [lkvc_pkg::FIELD_BITS-1:0]     read_value,
    output logic [lkvc_pkg::EVENT_BITS-1:0]     event_res,
    output logic                                evicted,
    output logic [lkvc_pkg::FIELD_BITS-1:0]     evicted_key
);

    import lkvc_pkg::*;

    localparam int CMP_BITS = (OCC_BITS > CAP_BITS) ? OCC_BITS : CAP_BITS;

    typedef enum logic {
        ST_IDLE,
        ST_UPDATE
    } state_t;

    state_t                  state_reg, state_next;
    logic [CAP_BITS-1:0]     cap_reg, cap_next;
    logic [OCC_BITS-1:0]     occ_reg, occ_next;
    logic [MODE_BITS-1:0]    mode_reg, mode_next;
    logic [KEY_BITS-1:0]     key_reg, key_next;
    logic [VALUE_BITS-1:0]   value_reg, value_next;
    logic                    hit_reg, hit_next;
    logic [RANK_BITS-1:0]    rank_reg, rank_next;
    logic [VALUE_BITS-1:0]   rd_reg, rd_next;
    logic [KEY_BITS-1:0]     evk_reg, evk_next;
    logic                    evict_reg, evict_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    out_hit_reg, out_hit_next;
    logic [FIELD_BITS-1:0]   out_rd_reg, out_rd_next;
    logic [EVENT_BITS-1:0]   out_ev_reg, out_ev_next;
    logic                    out_evd_reg, out_evd_next;
    logic [FIELD_BITS-1:0]   out_evk_reg, out_evk_next;

    logic                    in_acc;
    logic                    fire;
    logic [CMP_BITS-1:0]     cap_eff;
    logic                    is_get;
    logic                    is_put;
    logic                    is_erase;
    logic                    put_miss;

    // a capacity of zero acts as one, above the entry count as the entry count
    always_comb
    begin
        if (cap_reg == '0)
            cap_eff = CMP_BITS'(1);
        else if (CMP_BITS'(cap_reg) > CMP_BITS'(ENTRIES))
            cap_eff = CMP_BITS'(ENTRIES);
        else
            cap_eff = CMP_BITS'(cap_reg);
    end

    assign in_stall   = (state_reg != ST_IDLE);
    assign in_acc     = in_valid && !in_stall;
    assign fire       = (state_reg == ST_UPDATE) && (!out_valid_reg || !out_stall);
    assign cfg_ready  = 1'b1;

    assign look       = in_acc;
    assign lru_rank   = RANK_BITS'(occ_reg - OCC_BITS'(1));
    assign evict_look = (mode == MODE_PUT) && (CMP_BITS'(occ_reg) >= cap_eff);

    assign is_get   = (mode_reg == MODE_GET);
    assign is_put   = (mode_reg == MODE_PUT);
    assign is_erase = (mode_reg == MODE_ERASE);
    assign put_miss = is_put && !hit_reg;

    assign ref_rank  = rank_reg;
    assign new_key   = key_reg;
    assign new_value = value_reg;

    always_comb
    begin
        cmd.op    = OP_NOP;
        cmd.write = is_put;
        cmd.evict = evict_reg;
        if (fire)
        begin
            if ((is_get || is_put) && hit_reg)
                cmd.op = OP_TOUCH;
            else if (put_miss)
                cmd.op = OP_INSERT;
            else if (is_erase && hit_reg)
                cmd.op = OP_DROP;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cap_next       = cap_reg;
        occ_next       = occ_reg;
        mode_next      = mode_reg;
        key_next       = key_reg;
        value_next     = value_reg;
        hit_next       = hit_reg;
        rank_next      = rank_reg;
        rd_next        = rd_reg;
        evk_next       = evk_reg;
        evict_next     = evict_reg;
        out_valid_next = out_valid_reg;
        out_hit_next   = out_hit_reg;
        out_rd_next    = out_rd_reg;
        out_ev_next    = out_ev_reg;
        out_evd_next   = out_evd_reg;
        out_evk_next   = out_evk_reg;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        if (cfg_valid)
            cap_next = cfg_data;

        if (in_acc)
        begin
            state_next = ST_UPDATE;
            mode_next  = mode;
            key_next   = look_key;
            value_next = look_value;
            hit_next   = chain_end.hit;
            rank_next  = rank_end;
            rd_next    = value_end;
            evk_next   = evkey_end;
            evict_next = evict_look;
        end

        if (fire)
        begin
            state_next     = ST_IDLE;
            out_valid_next = 1'b1;
            out_hit_next   = hit_reg && (is_get || is_put || is_erase);
            out_rd_next    = (is_get && hit_reg) ? FIELD_BITS'(rd_reg) : '0;
            out_evd_next   = put_miss && evict_reg;
            out_evk_next   = (put_miss && evict_reg) ? FIELD_BITS'(evk_reg) : '0;
            if (is_put && hit_reg)
                out_ev_next = EV_UPDATE;
            else if (put_miss)
                out_ev_next = EV_INSERT;
            else if (is_erase && hit_reg)
                out_ev_next = EV_DELETE;
            else
                out_ev_next = EV_NONE;

            if (put_miss && !evict_reg)
                occ_next = occ_reg + OCC_BITS'(1);
            else if (is_erase && hit_reg)
                occ_next = occ_reg - OCC_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cap_reg       <= CAP_RESET;
            occ_reg       <= '0;
            mode_reg      <= '0;
            key_reg       <= '0;
            value_reg     <= '0;
            hit_reg       <= 1'b0;
            rank_reg      <= '0;
            rd_reg        <= '0;
            evk_reg       <= '0;
            evict_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            out_hit_reg   <= 1'b0;
            out_rd_reg    <= '0;
            out_ev_reg    <= EV_NONE;
            out_evd_reg   <= 1'b0;
            out_evk_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cap_reg       <= cap_next;
            occ_reg       <= occ_next;
            mode_reg      <= mode_next;
            key_reg       <= key_next;
            value_reg     <= value_next;
            hit_reg       <= hit_next;
            rank_reg      <= rank_next;
            rd_reg        <= rd_next;
            evk_reg       <= evk_next;
            evict_reg     <= evict_next;
            out_valid_reg <= out_valid_next;
            out_hit_reg   <= out_hit_next;
            out_rd_reg    <= out_rd_next;
            out_ev_reg    <= out_ev_next;
            out_evd_reg   <= out_evd_next;
            out_evk_reg   <= out_evk_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign hit         = out_hit_reg;
    assign read_value  = out_rd_reg;
    assign event_res   = out_ev_reg;
    assign evicted     = out_evd_reg;
    assign evicted_key = out_evk_reg;

endmodule

`default_nettype wire

// File: hdl/lru_key_value_cache_top.sv
// Top level of the LRU key/value cache: a row of entry cells and the sequencer.
//
//   channel | dir | handshake           | word
//   --------+-----+---------------------+------------------------------------------
//   in      | in  | in_valid / in_stall | mode, key, value
//   out     | out | out_valid/out_stall | hit, read_value, event_res, evicted,
//           |     |                     | evicted_key
//   cfg     | in  | cfg_valid/cfg_ready | cfg_data (capacity_in_use)
//
// Per word: the accept latches the key compare and LRU/free-slot chain of every
// cell; the update state then applies the update in all cells and loads the
// output register. A new word is taken only once the sequencer is back in idle.
// A stalled output holds the update cycle until the result register frees up.
// Reset empties the cache at once (valid flags clear), capacity resets to 16.
`default_nettype none

module lru_key_value_cache_top #(
    parameter int ENTRIES    = lkvc_pkg::DEF_ENTRIES,
    parameter int KEY_BITS   = lkvc_pkg::DEF_KEY_BITS,
    parameter int VALUE_BITS = lkvc_pkg::DEF_VALUE_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [lkvc_pkg::MODE_BITS-1:0]      mode,
    input  logic [lkvc_pkg::FIELD_BITS-1:0]     key,
    input  logic [lkvc_pkg::FIELD_BITS-1:0]     value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                hit,
    output logic [lkvc_pkg::FIELD_BITS-1:0]     read_value,
    output logic [lkvc_pkg::EVENT_BITS-1:0]     event_res,
    output logic                                evicted,
    output logic [lkvc_pkg::FIELD_BITS-1:0]     evicted_key,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lkvc_pkg::CAP_BITS-1:0]       cfg_data
);

    import lkvc_pkg::*;

    localparam int RANK_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_BITS  = $clog2(ENTRIES + 1);

    logic [KEY_BITS-1:0]   look_key;
    logic [VALUE_BITS-1:0] look_value;
    logic                  look;
    logic [RANK_BITS-1:0]  lru_rank;
    logic                  evict_look;
    cmd_t                  cmd;
    logic [RANK_BITS-1:0]  ref_rank;
    logic [KEY_BITS-1:0]   new_key;
    logic [VALUE_BITS-1:0] new_value;

    chain_t                chain_c [ENTRIES+1];
    logic [RANK_BITS-1:0]  rank_c  [ENTRIES+1];
    logic [VALUE_BITS-1:0] value_c [ENTRIES+1];
    logic [KEY_BITS-1:0]   evkey_c [ENTRIES+1];

    assign look_key   = KEY_BITS'(key);
    assign look_value = VALUE_BITS'(value);

    assign chain_c[0] = '0;
    assign rank_c[0]  = '0;
    assign value_c[0] = '0;
    assign evkey_c[0] = '0;

    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_cell
        lkvc_cell #(
            .KEY_BITS   (KEY_BITS),
            .VALUE_BITS (VALUE_BITS),
            .RANK_BITS  (RANK_BITS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .look       (look),
            .look_key   (look_key),
            .lru_rank   (lru_rank),
            .evict_look (evict_look),
            .cmd        (cmd),
            .ref_rank   (ref_rank),
            .new_key    (new_key),
            .new_value  (new_value),
            .chain_in   (chain_c[g]),
            .chain_out  (chain_c[g+1]),
            .rank_in    (rank_c[g]),
            .rank_out   (rank_c[g+1]),
            .value_in   (value_c[g]),
            .value_out  (value_c[g+1]),
            .evkey_in   (evkey_c[g]),
            .evkey_out  (evkey_c[g+1])
        );
    end

    lkvc_ctrl #(
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS),
        .ENTRIES    (ENTRIES),
        .RANK_BITS  (RANK_BITS),
        .OCC_BITS   (OCC_BITS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .look_key    (look_key),
        .look_value  (look_value),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .chain_end   (chain_c[ENTRIES]),
        .rank_end    (rank_c[ENTRIES]),
        .value_end   (value_c[ENTRIES]),
        .evkey_end   (evkey_c[ENTRIES]),
        .look        (look),
        .lru_rank    (lru_rank),
        .evict_look  (evict_look),
        .cmd         (cmd),
        .ref_rank    (ref_rank),
        .new_key     (new_key),
        .new_value   (new_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .hit         (hit),
        .read_value  (read_value),
        .event_res   (event_res),
        .evicted     (evicted),
        .evicted_key (evicted_key)
    );

endmodule

`default_nettype wire

// File: hdl/lkvc_checker.sv
// Port-level checks of the LRU key/value cache, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module lkvc_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic                                hit,
    input  logic [lkvc_pkg::FIELD_BITS-1:0]     read_value,
    input  logic [lkvc_pkg::EVENT_BITS-1:0]     event_res,
    input  logic                                evicted,
    input  logic [lkvc_pkg::FIELD_BITS-1:0]     evicted_key
);

    import lkvc_pkg::*;

    // the update cycle always follows an accepted word
    `ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "no update cycle after accept")

    `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(read_value) && $stable(event_res) && $stable(evicted_key), "stalled result changed")

    `ASSERT_IMP(a_evict_on_insert, out_valid && evicted, event_res == EV_INSERT && !hit, "eviction outside put miss")

    `ASSERT_IMP(a_read_on_get_hit, out_valid && read_value != '0, hit && event_res == EV_NONE, "read data without get hit")

    `ASSERT_IMP(a_hit_events, out_valid && (event_res == EV_UPDATE || event_res == EV_DELETE), hit && !evicted && evicted_key == '0, "update or delete without hit")

endmodule

bind lru_key_value_cache_top lkvc_checker u_lkvc_checker (.*);

`default_nettype wire
